[rtl/bre_pkg.sv]
`default_nettype none

package bre_pkg;

    // Map geometry
    localparam int WORD_BITS = 64;
    localparam int MAP_BITS  = 4096;
    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = $clog2(NUM_WORDS);
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int POS_W     = 13;

    // Operation codes
    typedef enum logic [2:0] {
        KIND_SET       = 3'd0,
        KIND_CLEAR     = 3'd1,
        KIND_GET       = 3'd2,
        KIND_FIND      = 3'd3,
        KIND_SCAN      = 3'd4,
        KIND_CLEAR_ALL = 3'd5
    } kind_t;

    // Result codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NO_RUN  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic rd;
        logic eval;
        logic put;
    } bre_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pre_done;
        logic eval_done;
        logic eval_stay;
        logic out_busy;
    } bre_sts_t;

endpackage

`default_nettype wire

[rtl/bre_ram.sv]
`default_nettype none

module bre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bre_ctrl.sv]
`default_nettype none

module bre_ctrl
    import bre_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire bre_sts_t sts,
    output bre_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.pre_done ? S_DONE : S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (sts.eval_done)
                    state_next = S_DONE;
                else if (sts.eval_stay)
                    state_next = S_EVAL;
                else
                    state_next = S_READ;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.put    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[rtl/bre_datapath.sv]
`default_nettype none

module bre_datapath
    import bre_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bre_cmd_t           cmd,
    output bre_sts_t                sts,
    input  wire logic               cfg_write_en,
    input  wire logic [POS_W-1:0]   cfg_write_data,
    input  wire logic [2:0]         kind,
    input  wire logic [POS_W-1:0]   bit_start,
    input  wire logic [POS_W-1:0]   bit_end,
    input  wire logic [POS_W-1:0]   run_length,
    input  wire logic               bit_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [POS_W-1:0]        position,
    output logic                    all_match
);

    localparam logic [POS_W-1:0] MAP_LIMIT = POS_W'(MAP_BITS);
    localparam logic [POS_W:0]   WORD_STEP = (POS_W+1)'(WORD_BITS);

    // Control state
    logic [POS_W-1:0]     size_reg;
    logic [NUM_WORDS-1:0] valid_reg;
    logic                 out_valid_reg;
    logic                 run_open_reg;
    logic                 run_open_next;

    // Item and walk registers
    kind_t            kind_reg;
    logic [POS_W-1:0] bs_reg;
    logic [POS_W-1:0] be_reg;
    logic [POS_W-1:0] e_reg;
    logic [POS_W-1:0] rl_reg;
    logic             v_reg;
    logic [POS_W-1:0] p_reg;
    logic [POS_W-1:0] p_next;
    logic [POS_W-1:0] runst_reg;
    logic [POS_W-1:0] runst_next;
    logic [1:0]       res_status_reg;
    logic [1:0]       res_status_next;
    logic [POS_W-1:0] res_pos_reg;
    logic [POS_W-1:0] res_pos_next;
    logic             res_all_reg;
    logic             res_all_next;
    logic [1:0]       status_reg;
    logic [POS_W-1:0] position_reg;
    logic             all_match_reg;

    // Precheck results
    logic             pre_done;
    logic [1:0]       pre_status;
    logic [POS_W-1:0] pre_pos;
    logic             pre_all;

    // Word evaluation
    logic [ADDR_W-1:0]    word_idx;
    logic [OFF_W-1:0]     lo;
    logic [POS_W-1:0]     base;
    logic [POS_W:0]       base_step;
    logic                 end_word;
    logic [POS_W-1:0]     e_off;
    logic [OFF_W:0]       hi_cnt;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] diff_bits;
    logic [WORD_BITS-1:0] srch_bits;
    logic                 match_val;
    logic                 hit;
    logic [OFF_W-1:0]     hit_idx;
    logic [POS_W-1:0]     hit_pos;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic                 eval_done;
    logic                 eval_stay;
    logic [ADDR_W-1:0]    clr_last;
    logic [POS_W-1:0]     size_m1;

    // Lowest set bit of a word
    function automatic logic [OFF_W:0] first_set(input logic [WORD_BITS-1:0] x);
        logic [OFF_W:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (x[i])
                r = {1'b1, OFF_W'(i)};
        end
        return r;
    endfunction

    bre_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (word_idx),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (word_idx),
        .rdata (rdata)
    );

    // Argument checks and trivial outcomes
    always_comb
    begin
        pre_done   = 1'b1;
        pre_status = ST_OK;
        pre_pos    = '0;
        pre_all    = 1'b0;
        unique case (kind_reg)
            KIND_SET, KIND_CLEAR:
            begin
                if (bs_reg > be_reg || be_reg > size_reg)
                    pre_status = ST_INVALID;
                else if (bs_reg != be_reg)
                    pre_done = 1'b0;
            end
            KIND_GET, KIND_SCAN:
            begin
                if (bs_reg >= e_reg)
                begin
                    pre_pos = e_reg;
                    pre_all = (kind_reg == KIND_GET);
                end
                else
                    pre_done = 1'b0;
            end
            KIND_FIND:
            begin
                if (be_reg <= bs_reg)
                    pre_status = ST_INVALID;
                else if (rl_reg == '0 || bs_reg >= e_reg)
                    pre_pos = bs_reg;
                else
                    pre_done = 1'b0;
            end
            KIND_CLEAR_ALL: pre_done = 1'b1;
            default:        pre_status = ST_INVALID;
        endcase
    end

    // Current word geometry and masks
    assign word_idx   = p_reg[OFF_W+ADDR_W-1:OFF_W];
    assign lo         = p_reg[OFF_W-1:0];
    assign base       = {p_reg[POS_W-1:OFF_W], {OFF_W{1'b0}}};
    assign base_step  = {1'b0, base} + WORD_STEP;
    assign end_word   = ({1'b0, e_reg} <= base_step);
    assign e_off      = e_reg - base;
    assign hi_cnt     = end_word ? e_off[OFF_W:0] : (OFF_W+1)'(WORD_BITS);
    assign lo_mask    = {WORD_BITS{1'b1}} << lo;
    assign hi_mask    = hi_cnt[OFF_W] ? {WORD_BITS{1'b1}}
                                      : ~({WORD_BITS{1'b1}} << hi_cnt[OFF_W-1:0]);
    assign range_mask = lo_mask & hi_mask;
    assign word       = valid_reg[word_idx] ? rdata : '0;

    // Bits that differ from the value sought; an unopened run searches for equal bits
    assign match_val = (kind_reg == KIND_GET) ? 1'b1 : v_reg;
    assign diff_bits = (word ^ {WORD_BITS{match_val}}) & range_mask;
    assign srch_bits = (kind_reg == KIND_FIND && !run_open_reg)
                     ? (~(word ^ {WORD_BITS{match_val}}) & range_mask) : diff_bits;
    assign {hit, hit_idx} = first_set(srch_bits);
    assign hit_pos   = {p_reg[POS_W-1:OFF_W], hit_idx};
    assign wdata     = (kind_reg == KIND_SET) ? (word | range_mask) : (word & ~range_mask);
    assign we        = cmd.eval && (kind_reg == KIND_SET || kind_reg == KIND_CLEAR);

    // One evaluation step on the current word
    always_comb
    begin
        eval_done       = 1'b0;
        eval_stay       = 1'b0;
        p_next          = base_step[POS_W-1:0];
        runst_next      = runst_reg;
        run_open_next   = run_open_reg;
        res_status_next = ST_OK;
        res_pos_next    = '0;
        res_all_next    = 1'b0;
        unique case (kind_reg)
            KIND_GET, KIND_SCAN:
            begin
                if (hit)
                begin
                    eval_done    = 1'b1;
                    res_pos_next = hit_pos;
                end
                else if (end_word)
                begin
                    eval_done    = 1'b1;
                    res_pos_next = e_reg;
                    res_all_next = (kind_reg == KIND_GET);
                end
            end
            KIND_FIND:
            begin
                if (!run_open_reg)
                begin
                    if (hit)
                    begin
                        if ((e_reg - hit_pos) < rl_reg)
                        begin
                            eval_done       = 1'b1;
                            res_status_next = ST_NO_RUN;
                            res_pos_next    = be_reg;
                        end
                        else
                        begin
                            eval_stay     = 1'b1;
                            p_next        = hit_pos;
                            runst_next    = hit_pos;
                            run_open_next = 1'b1;
                        end
                    end
                    else if (end_word)
                    begin
                        eval_done       = 1'b1;
                        res_status_next = ST_NO_RUN;
                        res_pos_next    = be_reg;
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        if ((hit_pos - runst_reg) >= rl_reg)
                        begin
                            eval_done    = 1'b1;
                            res_pos_next = runst_reg;
                        end
                        else
                        begin
                            eval_stay     = 1'b1;
                            p_next        = hit_pos;
                            run_open_next = 1'b0;
                        end
                    end
                    else if (end_word)
                    begin
                        eval_done    = 1'b1;
                        res_pos_next = runst_reg;
                    end
                end
            end
            default:
            begin
                eval_done = end_word;
            end
        endcase
    end

    assign sts.pre_done  = pre_done;
    assign sts.eval_done = eval_done;
    assign sts.eval_stay = eval_stay;
    assign sts.out_busy  = out_valid_reg && out_stall;

    assign size_m1  = size_reg - 1'b1;
    assign clr_last = size_m1[OFF_W+ADDR_W-1:OFF_W];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= MAP_LIMIT;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            run_open_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                size_reg <= (cfg_write_data > MAP_LIMIT) ? MAP_LIMIT : cfg_write_data;

            if (cmd.check && kind_reg == KIND_CLEAR_ALL && size_reg != '0)
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    if (ADDR_W'(i) <= clr_last)
                        valid_reg[i] <= 1'b0;
                end
            end
            else if (we)
                valid_reg[word_idx] <= 1'b1;

            if (cmd.put)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cmd.load)
                run_open_reg <= 1'b0;
            else if (cmd.eval)
                run_open_reg <= run_open_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind_t'(kind);
            bs_reg   <= bit_start;
            be_reg   <= bit_end;
            rl_reg   <= run_length;
            v_reg    <= bit_value;
            p_reg    <= bit_start;
            if (kind == KIND_SET || kind == KIND_CLEAR)
                e_reg <= bit_end;
            else
                e_reg <= (bit_end < size_reg) ? bit_end : size_reg;
        end
        if (cmd.check)
        begin
            res_status_reg <= pre_status;
            res_pos_reg    <= pre_pos;
            res_all_reg    <= pre_all;
        end
        if (cmd.eval)
        begin
            p_reg     <= p_next;
            runst_reg <= runst_next;
            if (eval_done)
            begin
                res_status_reg <= res_status_next;
                res_pos_reg    <= res_pos_next;
                res_all_reg    <= res_all_next;
            end
        end
        if (cmd.put)
        begin
            status_reg    <= res_status_reg;
            position_reg  <= res_pos_reg;
            all_match_reg <= res_all_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;
    assign all_match = all_match_reg;

endmodule

`default_nettype wire

[rtl/bitmap_range_engine_core.sv]
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall  kind, bit_start, bit_end, run_length, bit_value
// out       result     out_valid/out_stall  status, position, all_match
// cfg       write      cfg_write_en         cfg_write_data (size_in_use)
//
// One request at a time: a load and an argument check, then a RAM read and
// an evaluate step per 64-bit word visited, plus an extra evaluate step each
// time find opens or breaks a run, then a step to post the result.
// Clear all, like any request settled by the argument check, visits no word.
// The map RAM has one read and one write port; per-word valid flops stand in
// for zeroed words, so reset and clear all need no sweep.
// A stalled result is held in the output register while the next request
// is accepted and worked on.
`default_nettype none

module bitmap_range_engine_core
    import bre_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [POS_W-1:0]   cfg_write_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         kind,
    input  wire logic [POS_W-1:0]   bit_start,
    input  wire logic [POS_W-1:0]   bit_end,
    input  wire logic [POS_W-1:0]   run_length,
    input  wire logic               bit_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [POS_W-1:0]        position,
    output logic                    all_match
);

    bre_cmd_t cmd;
    bre_sts_t sts;

    bre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bre_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .kind           (kind),
        .bit_start      (bit_start),
        .bit_end        (bit_end),
        .run_length     (run_length),
        .bit_value      (bit_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .position       (position),
        .all_match      (all_match)
    );

    // At most one command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.check, cmd.rd, cmd.eval, cmd.put}))
        else $error("more than one datapath command");

    // An accepted request blocks the input until it completes
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // A posted result is presented next cycle
    a_put_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |=> out_valid)
        else $error("result not presented");

endmodule

`default_nettype wire

[bench/bitmap_range_engine_core_test.sv]
`default_nettype none

module bitmap_range_engine_core_test;
    import bre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes outside the defined operation set
    localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED_7 = 3'd7;
    localparam int POS_MAX = (1 << POS_W) - 1;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic             all_match;
    } outcome_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [POS_W-1:0]   cfg_write_data;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         kind;
    logic [POS_W-1:0]   bit_start;
    logic [POS_W-1:0]   bit_end;
    logic [POS_W-1:0]   run_length;
    logic               bit_value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [POS_W-1:0]   position;
    logic               all_match;

    // Shadow copy of the map and the size register
    logic [MAP_BITS-1:0] shadow_map;
    int unsigned         shadow_size;

    outcome_t pending_outcomes[$];
    int       error_count;
    int       accepted_requests;
    bit       sender_idles;
    bit       receiver_idles;
    int       hold_left;
    int       stall_burst;

    bitmap_range_engine_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .bit_start      (bit_start),
        .bit_end        (bit_end),
        .run_length     (run_length),
        .bit_value      (bit_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .position       (position),
        .all_match      (all_match)
    );

    always #5 clk = ~clk;

    // First position in [s, min(e, size)) whose bit differs from v, else clamped end
    function automatic int unsigned first_mismatch(int unsigned s, int unsigned e, bit v);
        int unsigned lim;
        lim = (e < shadow_size) ? e : shadow_size;
        for (int unsigned p = s; p < lim; p++)
            if (shadow_map[p] != v)
                return p;
        return lim;
    endfunction

    // Apply one request to the shadow map and return its outcome
    function automatic outcome_t apply_request(logic [2:0] k, int unsigned bs, int unsigned be,
                                               int unsigned rl, bit v);
        outcome_t    res;
        int unsigned lim;
        int unsigned cur;
        int unsigned st;
        int unsigned last;
        res = '0;
        case (k)
            KIND_SET, KIND_CLEAR:
            begin
                if (bs > be || be > shadow_size)
                    res.status = ST_INVALID;
                else
                    for (int unsigned p = bs; p < be; p++)
                        shadow_map[p] = (k == KIND_SET);
            end
            KIND_GET:
            begin
                lim = (be < shadow_size) ? be : shadow_size;
                res.position = POS_W'(first_mismatch(bs, lim, 1'b1));
                res.all_match = (res.position == lim);
            end
            KIND_FIND:
            begin
                if (be <= bs)
                begin
                    res.status = ST_INVALID;
                end
                else
                begin
                    lim = (be < shadow_size) ? be : shadow_size;
                    cur = bs;
                    st = bs;
                    while (cur - st < rl && cur < lim && res.status == ST_OK)
                    begin
                        st = first_mismatch(cur, lim, ~v);
                        if (st > lim || lim - st < rl)
                        begin
                            res.status = ST_NO_RUN;
                            res.position = POS_W'(be);
                        end
                        else
                        begin
                            cur = first_mismatch(st, st + rl, v);
                        end
                    end
                    if (res.status == ST_OK)
                        res.position = POS_W'(st);
                end
            end
            KIND_SCAN:
                res.position = POS_W'(first_mismatch(bs, be, v));
            KIND_CLEAR_ALL:
            begin
                if (shadow_size != 0)
                begin
                    last = (shadow_size - 1) / WORD_BITS;
                    for (int unsigned i = 0; i <= last && i < NUM_WORDS; i++)
                        shadow_map[i*WORD_BITS +: WORD_BITS] = '0;
                end
            end
            default:
                res.status = ST_INVALID;
        endcase
        return res;
    endfunction

    // Predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            pending_outcomes.push_back(apply_request(kind, bit_start, bit_end,
                                                     run_length, bit_value));
            accepted_requests++;
        end
    end

    // Check every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d position=%0d all_match=%0d",
                         $time, status, position, all_match);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    error_count++;
                end
                if (position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, position);
                    error_count++;
                end
                if (all_match !== want.all_match)
                begin
                    $display("%0t: all_match expected %0d actual %0d",
                             $time, want.all_match, all_match);
                    error_count++;
                end
            end
        end
    end

    // Result side stall: long hold when asked, else random bursts
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (stall_burst > 0)
        begin
            out_stall = 1'b1;
            stall_burst--;
        end
        else if (receiver_idles && $urandom_range(0, 5) == 0)
        begin
            out_stall = 1'b1;
            stall_burst = $urandom_range(0, 8);
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    // Offer one request and wait until it is taken; called at a falling edge
    task automatic send_request(logic [2:0] k, int unsigned bs, int unsigned be,
                                int unsigned rl, bit v);
        int taken;
        taken = accepted_requests;
        kind = k;
        bit_start = bs[POS_W-1:0];
        bit_end = be[POS_W-1:0];
        run_length = rl[POS_W-1:0];
        bit_value = v;
        in_valid = 1'b1;
        do
            @(negedge clk);
        while (accepted_requests == taken);
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_size(int unsigned value);
        wait_drained();
        cfg_write_en = 1'b1;
        cfg_write_data = value[POS_W-1:0];
        @(negedge clk);
        cfg_write_en = 1'b0;
        shadow_size = (value > MAP_BITS) ? MAP_BITS : value;
    endtask

    function automatic int unsigned pick_pos();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, POS_MAX);
            1: return shadow_size;
            2: return 0;
            default: return $urandom_range(0, shadow_size);
        endcase
    endfunction

    // Mostly well-formed operations on nearby ranges, some out of range noise
    task automatic send_random_request();
        logic [2:0]  k;
        int unsigned bs;
        int unsigned be;
        int unsigned rl;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20)      k = KIND_SET;
        else if (r < 35) k = KIND_CLEAR;
        else if (r < 52) k = KIND_GET;
        else if (r < 75) k = KIND_FIND;
        else if (r < 93) k = KIND_SCAN;
        else if (r < 97) k = KIND_CLEAR_ALL;
        else             k = $urandom_range(0, 1) ? KIND_UNUSED_6 : KIND_UNUSED_7;
        bs = pick_pos();
        if ($urandom_range(0, 5) == 0)
            be = pick_pos();
        else
            be = (bs + $urandom_range(0, 400)) & POS_MAX;
        if ($urandom_range(0, 9) == 0)
            rl = $urandom_range(0, POS_MAX);
        else
            rl = $urandom_range(0, 90);
        send_request(k, bs, be, rl, 1'($urandom_range(0, 1)));
    endtask

    // Every operation and the boundary cases at full size
    task automatic test_directed();
        send_request(KIND_SET, 0, MAP_BITS, 0, 0);
        send_request(KIND_GET, 0, MAP_BITS, 0, 0);
        send_request(KIND_CLEAR, 100, 200, 0, 0);
        send_request(KIND_GET, 0, MAP_BITS, 0, 0);
        send_request(KIND_SCAN, 0, POS_MAX, 0, 1);
        send_request(KIND_FIND, 0, MAP_BITS, 100, 0);
        send_request(KIND_FIND, 0, MAP_BITS, 101, 0);
        send_request(KIND_FIND, 50, MAP_BITS, 0, 1);
        send_request(KIND_FIND, 300, 300, 5, 1);
        send_request(KIND_FIND, 4000, POS_MAX, 200, 1);
        send_request(KIND_FIND, 0, POS_MAX, POS_MAX, 1);
        send_request(KIND_SET, 20, 10, 0, 0);
        send_request(KIND_SET, 0, MAP_BITS + 1, 0, 0);
        send_request(KIND_CLEAR, 77, 77, 0, 0);
        send_request(KIND_GET, POS_MAX, POS_MAX, 0, 1);
        send_request(KIND_SCAN, POS_MAX, 10, 0, 0);
        send_request(KIND_SCAN, 4095, POS_MAX, POS_MAX, 1);
        send_request(KIND_CLEAR_ALL, 0, 0, 0, 0);
        send_request(KIND_GET, 0, 64, 0, 0);
        send_request(KIND_UNUSED_6, POS_MAX, POS_MAX, POS_MAX, 1);
        send_request(KIND_UNUSED_7, 0, 0, 0, 0);
    endtask

    // Size extremes, saturation, and clear all leaving the tail word clear
    task automatic test_sizes();
        write_size(0);
        send_request(KIND_SET, 0, 0, 0, 0);
        send_request(KIND_SET, 0, 1, 0, 0);
        send_request(KIND_GET, 0, 10, 0, 0);
        send_request(KIND_CLEAR_ALL, 0, 0, 0, 0);
        write_size(POS_MAX);
        send_request(KIND_SET, 0, MAP_BITS, 0, 0);
        write_size(65);
        send_request(KIND_CLEAR_ALL, 0, 0, 0, 0);
        write_size(MAP_BITS);
        send_request(KIND_SCAN, 0, MAP_BITS, 0, 0);
        send_request(KIND_FIND, 0, MAP_BITS, 128, 0);
        write_size(1);
        send_request(KIND_SET, 0, 1, 0, 0);
        send_request(KIND_FIND, 0, 2, 1, 1);
        write_size(MAP_BITS);
    endtask

    // Random requests with size changes between phases
    task automatic test_random(int count);
        int unsigned sizes[9] = '{0, 1, 63, 64, 65, 4095, 4096, 8191, 1000};
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 149)
            begin
                if ($urandom_range(0, 2) == 0)
                    write_size($urandom_range(0, POS_MAX));
                else
                    write_size(sizes[$urandom_range(0, 8)]);
            end
            send_random_request();
        end
    endtask

    // Long receiver hold so the block backs up, then a full drain
    task automatic test_backpressure();
        hold_left = 400;
        for (int i = 0; i < 12; i++)
            send_random_request();
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        kind = KIND_SET;
        bit_start = '0;
        bit_end = '0;
        run_length = '0;
        bit_value = 1'b0;
        out_stall = 1'b0;
        shadow_map = '0;
        shadow_size = MAP_BITS;
        error_count = 0;
        accepted_requests = 0;
        hold_left = 0;
        stall_burst = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_sizes();
        test_backpressure();
        test_random(950);
        wait_drained();
        write_size(MAP_BITS);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        test_random(120);
        wait_drained();

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
